// ===== rtl/core/lln_pkg.sv =====
// Shared constants, types and helpers for the least-loaded node assigner.
// No dependencies; used by least_loaded_node_assigner_top, lln_assign_checker and testbench.
package lln_pkg;

    localparam int MAX_NODES = 16;
    localparam int LOAD_BITS = 48;
    localparam int NODE_W    = 4;
    localparam int WEIGHT_W  = 32;
    localparam int ACTIVE_W  = 5;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    localparam int IN_BITS   = 2 + NODE_W + WEIGHT_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = NODE_W + LOAD_BITS;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PRELOAD = 2'd1,
        CMD_WASSIGN = 2'd2,
        CMD_RRASSIGN = 2'd3
    } cmd_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PRE_RD = 7'b0000010,
        ST_PRE_WR = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_AS_WR  = 7'b0010000,
        ST_RR_RD  = 7'b0100000,
        ST_RR_OUT = 7'b1000000
    } state_t;

    // add with clamp at the all-ones load value
    function automatic logic [LOAD_BITS-1:0] sat_add(input logic [LOAD_BITS-1:0] a,
                                                     input logic [WEIGHT_W-1:0] w);
        logic [LOAD_BITS:0] s;
        s = {1'b0, a} + (LOAD_BITS + 1)'(w);
        return s[LOAD_BITS] ? {LOAD_BITS{1'b1}} : s[LOAD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/least_loaded_node_assigner_top.sv =====
// Least-loaded node assigner: per-node loads in one RAM, read-modify-write.
// Weighted assign reads each active node once in the min scan, then writes back;
// round-robin reads the pointed node; clear acts in idle; preload reads then writes.
// One item at a time; input ready only in idle. Output register frees input.
// Reset (rst_n low, async): loads read as zero via per-entry valid bits,
// round-robin pointer 0, active_nodes 16. Depends on lln_pkg, lln_ram.
module least_loaded_node_assigner_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // config: active_nodes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lln_pkg::ACTIVE_W-1:0] cfg_data,
    // tdata: cmd[1:0], node[5:2], weight[37:6], zero pad
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lln_pkg::IN_W-1:0]    s_axis_tdata,
    // tdata: assigned_node[3:0], load_after[51:4], zero pad
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [lln_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int AW = lln_pkg::ADDR_W;
    localparam int CW = lln_pkg::CNT_W;
    localparam int LW = lln_pkg::LOAD_BITS;

    // ---------------- registers ----------------
    lln_pkg::state_t               state_reg, state_next;
    logic [lln_pkg::ACTIVE_W-1:0]  active_reg;
    logic [lln_pkg::MAX_NODES-1:0] valid_reg, valid_next;
    logic [AW-1:0]                 rr_reg, rr_next;
    logic [AW-1:0]                 node_reg, node_next;      // preload target / RR pick
    logic [lln_pkg::WEIGHT_W-1:0]  weight_reg, weight_next;
    logic [CW-1:0]                 scan_idx_reg, scan_idx_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]                 cmp_idx_reg, cmp_idx_next;
    logic [LW-1:0]                 min_reg, min_next;
    logic [AW-1:0]                 pick_reg, pick_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lln_pkg::NODE_W-1:0]    out_node_reg, out_node_next;
    logic [LW-1:0]                 out_load_reg, out_load_next;

    // ---------------- RAM ----------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [LW-1:0] ram_wdata, ram_rdata;

    lln_ram #(
        .WIDTH (LW),
        .DEPTH (lln_pkg::MAX_NODES)
    ) u_load_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ---------------- decode ----------------
    logic [1:0]                   in_cmd;
    logic [lln_pkg::NODE_W-1:0]   in_node;
    logic [lln_pkg::WEIGHT_W-1:0] in_weight;
    logic [CW-1:0]                count;
    logic                         in_acc, out_free;
    logic [AW-1:0]                rr_pick;
    logic [AW-1:0]                rd_node;   // index of the data now on ram_rdata
    logic [LW-1:0]                rd_load;   // RAM data, zero for never-written entries
    logic                         scan_rd;

    assign in_cmd    = s_axis_tdata[1:0];
    assign in_node   = s_axis_tdata[2 +: lln_pkg::NODE_W];
    assign in_weight = s_axis_tdata[2 + lln_pkg::NODE_W +: lln_pkg::WEIGHT_W];

    // effective active count: 0 acts as 1, clamp at MAX_NODES
    always_comb
    begin
        if (active_reg == '0)
            count = CW'(1);
        else if (32'(active_reg) > lln_pkg::MAX_NODES)
            count = CW'(lln_pkg::MAX_NODES);
        else
            count = CW'(active_reg);
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == lln_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;

    // stale pointer wraps to zero
    assign rr_pick = (CW'(rr_reg) >= count) ? '0 : rr_reg;

    assign rd_node = (state_reg == lln_pkg::ST_SCAN) ? cmp_idx_reg : node_reg;
    assign rd_load = valid_reg[rd_node] ? ram_rdata : '0;
    assign scan_rd = (scan_idx_reg < count);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(lln_pkg::OUT_W - lln_pkg::OUT_BITS){1'b0}},
                            out_load_reg, out_node_reg};

    // ---------------- control ----------------
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        rr_next        = rr_reg;
        node_next      = node_reg;
        weight_next    = weight_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        min_next       = min_reg;
        pick_next      = pick_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_node_next  = out_node_reg;
        out_load_next  = out_load_reg;
        ram_we         = 1'b0;
        ram_waddr      = node_reg;
        ram_wdata      = lln_pkg::sat_add(rd_load, weight_reg);
        ram_raddr      = node_reg;

        unique case (state_reg)
            lln_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    weight_next = in_weight;
                    case (in_cmd)
                        lln_pkg::CMD_CLEAR:
                        begin
                            valid_next = '0;
                            rr_next    = '0;
                        end
                        lln_pkg::CMD_PRELOAD:
                        begin
                            node_next = AW'(in_node);
                            // preload to an inactive node is dropped
                            if (CW'(in_node) < count)
                                state_next = lln_pkg::ST_PRE_RD;
                        end
                        lln_pkg::CMD_WASSIGN:
                        begin
                            scan_idx_next = '0;
                            state_next    = lln_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            node_next  = rr_pick;
                            rr_next    = (CW'(rr_pick) + CW'(1) >= count) ? '0
                                                                          : rr_pick + AW'(1);
                            state_next = lln_pkg::ST_RR_RD;
                        end
                    endcase
                end
            end

            lln_pkg::ST_PRE_RD:
            begin
                state_next = lln_pkg::ST_PRE_WR;
            end

            lln_pkg::ST_PRE_WR:
            begin
                ram_we                = 1'b1;
                valid_next[node_reg]  = 1'b1;
                state_next            = lln_pkg::ST_IDLE;
            end

            lln_pkg::ST_SCAN:
            begin
                // issue one read per cycle, compare the one that came back
                ram_raddr    = AW'(scan_idx_reg);
                cmp_vld_next = scan_rd;
                cmp_idx_next = AW'(scan_idx_reg);
                if (scan_rd)
                    scan_idx_next = scan_idx_reg + CW'(1);
                if (cmp_vld_reg)
                begin
                    // strict less-than keeps the lowest index on ties
                    if (cmp_idx_reg == '0 || rd_load < min_reg)
                    begin
                        min_next  = rd_load;
                        pick_next = cmp_idx_reg;
                    end
                end
                if (!scan_rd && !cmp_vld_reg)
                    state_next = lln_pkg::ST_AS_WR;
            end

            lln_pkg::ST_AS_WR:
            begin
                if (out_free)
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = pick_reg;
                    ram_wdata             = lln_pkg::sat_add(min_reg, weight_reg);
                    valid_next[pick_reg]  = 1'b1;
                    out_valid_next        = 1'b1;
                    out_node_next         = lln_pkg::NODE_W'(pick_reg);
                    out_load_next         = lln_pkg::sat_add(min_reg, weight_reg);
                    state_next            = lln_pkg::ST_IDLE;
                end
            end

            lln_pkg::ST_RR_RD:
            begin
                state_next = lln_pkg::ST_RR_OUT;
            end

            lln_pkg::ST_RR_OUT:
            begin
                // hold the read address so the data stays while the output is full
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = lln_pkg::NODE_W'(node_reg);
                    out_load_next  = rd_load;
                    state_next     = lln_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lln_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lln_pkg::ST_IDLE;
            active_reg    <= lln_pkg::ACTIVE_W'(16);
            valid_reg     <= '0;
            rr_reg        <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rr_reg        <= rr_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                active_reg <= cfg_data;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        weight_reg   <= weight_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        min_reg      <= min_next;
        pick_reg     <= pick_next;
        out_node_reg <= out_node_next;
        out_load_reg <= out_load_next;
    end

endmodule

// ===== rtl/core/lln_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lln_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/sv/lln_assign_checker.sv =====
// Checker for the least-loaded node assigner: watches config, input and result streams,
// predicts each placement and compares it field by field. Depends on lln_pkg.
module lln_assign_checker
    import lln_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [ACTIVE_W-1:0]  cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // cmd, node, weight, zero pad
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,   // assigned_node, load_after, zero pad
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [NODE_W-1:0]    node;
        logic [LOAD_BITS-1:0] load;
    } placement_t;

    placement_t           placements_due[$];
    logic [LOAD_BITS-1:0] node_loads [MAX_NODES];
    logic [NODE_W-1:0]    rr_pointer;
    logic [ACTIVE_W-1:0]  active_setting;

    placement_t           want;
    logic [NODE_W-1:0]    seen_node;
    logic [LOAD_BITS-1:0] seen_load;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // effective node count: 0 behaves as 1, anything past MAX_NODES as MAX_NODES
    function automatic int live_nodes();
        if (active_setting == '0)
        begin
            return 1;
        end
        return (int'(active_setting) > MAX_NODES) ? MAX_NODES : int'(active_setting);
    endfunction

    function automatic logic [LOAD_BITS-1:0] clamp_add(input logic [LOAD_BITS-1:0] load,
                                                       input logic [WEIGHT_W-1:0] weight);
        logic [LOAD_BITS-1:0] room;
        room = {LOAD_BITS{1'b1}} - load;
        return (LOAD_BITS'(weight) > room) ? {LOAD_BITS{1'b1}} : load + LOAD_BITS'(weight);
    endfunction

    task automatic predict_placement(input logic [IN_W-1:0] item);
        cmd_t                cmd;
        logic [NODE_W-1:0]   node;
        logic [WEIGHT_W-1:0] weight;
        int                  count;
        int                  pick;
        placement_t          due;
        cmd    = cmd_t'(item[1:0]);
        node   = item[2 +: NODE_W];
        weight = item[2 + NODE_W +: WEIGHT_W];
        count  = live_nodes();
        case (cmd)
            CMD_CLEAR:
            begin
                foreach (node_loads[i])
                begin
                    node_loads[i] = '0;
                end
                rr_pointer = '0;
            end
            CMD_PRELOAD:
            begin
                // inactive targets are dropped
                if (int'(node) < count)
                begin
                    node_loads[node] = clamp_add(node_loads[node], weight);
                end
            end
            CMD_WASSIGN:
            begin
                pick = 0;
                for (int i = 1; i < count; i++)
                begin
                    if (node_loads[i] < node_loads[pick])
                    begin
                        pick = i;
                    end
                end
                node_loads[pick] = clamp_add(node_loads[pick], weight);
                due.node = NODE_W'(pick);
                due.load = node_loads[pick];
                placements_due = {placements_due, due};
            end
            default:
            begin
                // pointer left stale by a smaller active count restarts at 0
                if (int'(rr_pointer) >= count)
                begin
                    rr_pointer = '0;
                end
                pick       = int'(rr_pointer);
                rr_pointer = (pick + 1 >= count) ? '0 : NODE_W'(pick + 1);
                due.node   = NODE_W'(pick);
                due.load   = node_loads[pick];
                placements_due = {placements_due, due};
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (node_loads[i])
            begin
                node_loads[i] = '0;
            end
            rr_pointer     = '0;
            active_setting = ACTIVE_W'(MAX_NODES);
            placements_due.delete();
            mismatches     = 0;
            outstanding    = 0;
        end
        else
        begin
            // results first: one accepted here always belongs to an older item
            if (m_tvalid && m_tready)
            begin
                seen_node = m_tdata[0 +: NODE_W];
                seen_load = m_tdata[NODE_W +: LOAD_BITS];
                if (placements_due.size() == 0)
                begin
                    report_mismatch($sformatf("result node %0d load %0h with none pending",
                                              seen_node, seen_load));
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (seen_node !== want.node)
                    begin
                        report_mismatch($sformatf("assigned_node got %0d want %0d",
                                                  seen_node, want.node));
                    end
                    if (seen_load !== want.load)
                    begin
                        report_mismatch($sformatf("load_after got %0h want %0h",
                                                  seen_load, want.load));
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                active_setting = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                predict_placement(s_tdata);
            end
            outstanding = placements_due.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the least-loaded node assigner testbench: clock, reset, stimulus and verdict.
// Depends on lln_pkg, least_loaded_node_assigner_top and lln_assign_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lln_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    // margin past the worst accept-to-result, a full scan of all MAX_NODES nodes
    localparam int SETTLE_CYCLES = MAX_NODES + 14;
    localparam int DRAIN_LIMIT   = 20000;
    // max-weight adds that carry one load well past 32 bits
    localparam int FILL_ITEMS    = 32;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 150;
    // allow roughly five times the slowest clean run (all items at their longest gaps
    // and stalls)
    localparam longint RUN_LIMIT_NS = 10_000_000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ACTIVE_W-1:0] cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;   // cmd[1:0], node[5:2], weight[37:6], pad
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;        // assigned_node[3:0], load_after[51:4], pad

    int mismatches;
    int outstanding;
    // when set, neither side inserts idle cycles
    bit steady = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    least_loaded_node_assigner_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lln_assign_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Result side back-pressure. Decided at each falling edge, one assignment per
    // step: mostly ready, with stalls that are mostly short and now and then long.
    initial
    begin : result_pacing
        int hold;
        int r;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                hold          = 0;
                m_axis_tready = 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                m_axis_tready = 1'b0;
            end
            else if ($urandom_range(99) < 25)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    hold = $urandom_range(2, 0);
                end
                else if (r < 95)
                begin
                    hold = $urandom_range(9, 3);
                end
                else
                begin
                    hold = $urandom_range(59, 19);
                end
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // One item: optional idle gap first, then present at a falling edge and hold until
    // accepted. tvalid stays high after acceptance until the next call or a drain, so
    // back-to-back items never drop and raise it in the same step.
    task automatic push_item(input cmd_t cmd, input logic [NODE_W-1:0] node,
                             input logic [WEIGHT_W-1:0] weight);
        int gap;
        int r;
        gap = 0;
        if (!steady)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                gap = 0;
            end
            else if (r < 85)
            begin
                gap = $urandom_range(3, 1);
            end
            else if (r < 97)
            begin
                gap = $urandom_range(12, 4);
            end
            else
            begin
                gap = $urandom_range(60, 20);
            end
        end
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tdata  = IN_W'({weight, node, cmd});
        s_axis_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // Stop sending, wait for every predicted result, then let extra cycles pass so
    // that a clear or preload still in flight is done. Ends on a falling edge.
    task automatic drain_results(input int extra);
        int waited;
        waited = 0;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (extra) @(negedge clk);
    endtask

    // active_nodes is only written with the block idle
    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        drain_results(SETTLE_CYCLES);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin : run_limit
        #(RUN_LIMIT_NS);
        $display("[least_loaded_node_assigner_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int                  r;
        int                  live;
        int                  hold_at;
        logic [ACTIVE_W-1:0] setting;
        cmd_t                cmd;
        logic [NODE_W-1:0]   node;
        logic [WEIGHT_W-1:0] weight;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // ---- directed: ties, round-robin, clear, inactive preload ----
        write_active(5'd16);
        push_item(CMD_WASSIGN, 4'd0, 32'h0);            // all tied at zero -> node 0
        push_item(CMD_WASSIGN, 4'd7, 32'hFFFF_FFFF);    // all still tied at zero -> node 0
        push_item(CMD_PRELOAD, 4'd15, 32'hFFFF_FFFF);
        push_item(CMD_PRELOAD, 4'd0, 32'd3);
        push_item(CMD_WASSIGN, 4'd15, 32'd1);           // lowest zero-load node
        push_item(CMD_RRASSIGN, 4'd15, 32'hFFFF_FFFF);  // weight ignored, present load
        push_item(CMD_RRASSIGN, 4'd0, 32'h0);
        push_item(CMD_CLEAR, 4'd15, 32'hFFFF_FFFF);     // loads and pointer back to zero
        push_item(CMD_RRASSIGN, 4'd9, 32'h1234_5678);

        write_active(5'd4);
        push_item(CMD_PRELOAD, 4'd4, 32'hFFFF_FFFF);    // inactive node, left alone
        push_item(CMD_PRELOAD, 4'd3, 32'd2);
        push_item(CMD_WASSIGN, 4'd0, 32'd5);
        repeat (5) push_item(CMD_RRASSIGN, 4'd0, 32'hAAAA_5555);  // wraps past node 3

        // pointer now equals the new count and must restart at node 0
        write_active(5'd2);
        push_item(CMD_RRASSIGN, 4'd1, 32'h0);

        // zero behaves as one node
        write_active(5'd0);
        push_item(CMD_WASSIGN, 4'd5, 32'd9);
        push_item(CMD_RRASSIGN, 4'd0, 32'd0);
        push_item(CMD_PRELOAD, 4'd1, 32'hFFFF_FFFF);

        // settings past MAX_NODES behave as MAX_NODES
        write_active(5'd31);
        push_item(CMD_RRASSIGN, 4'd0, 32'h0);
        push_item(CMD_PRELOAD, 4'd15, 32'h8000_0001);
        push_item(CMD_WASSIGN, 4'd0, 32'h5555_AAAA);
        write_active(5'd17);
        push_item(CMD_WASSIGN, 4'd0, 32'h0000_FFFF);

        // ---- wide loads: one node pumped well past 32 bits ----
        write_active(5'd1);
        steady = 1'b1;
        push_item(CMD_CLEAR, 4'd0, 32'h0);
        repeat (FILL_ITEMS) push_item(CMD_PRELOAD, 4'd0, 32'hFFFF_FFFF);
        push_item(CMD_PRELOAD, 4'd0, 32'h0000_FFFF);
        push_item(CMD_RRASSIGN, 4'd0, 32'h0);
        push_item(CMD_WASSIGN, 4'd0, 32'h0);
        push_item(CMD_WASSIGN, 4'd0, 32'hFFFF_FFFF);
        push_item(CMD_PRELOAD, 4'd0, 32'd1);
        push_item(CMD_RRASSIGN, 4'd0, 32'h0);
        steady = 1'b0;

        // ---- random phases, each under its own active count ----
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                setting = '0;
            end
            else if (r < 20)
            begin
                setting = ACTIVE_W'($urandom_range(31, 17));
            end
            else if (r < 30)
            begin
                setting = 5'd16;
            end
            else if (r < 40)
            begin
                setting = 5'd1;
            end
            else
            begin
                setting = ACTIVE_W'($urandom_range(16, 1));
            end
            write_active(setting);
            live    = (setting == '0) ? 1 :
                      (int'(setting) > MAX_NODES) ? MAX_NODES : int'(setting);
            // one phase runs with no idling on either side
            steady  = (phase == 2);
            // somewhere in each phase the sender waits for all results
            hold_at = $urandom_range(PHASE_ITEMS - 1, 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == hold_at)
                begin
                    drain_results(0);
                end
                r = $urandom_range(99);
                if (r < 3)
                begin
                    cmd = CMD_CLEAR;
                end
                else if (r < 33)
                begin
                    cmd = CMD_PRELOAD;
                end
                else if (r < 73)
                begin
                    cmd = CMD_WASSIGN;
                end
                else
                begin
                    cmd = CMD_RRASSIGN;
                end
                // mostly active targets so preloads land and shape the minimum search
                if ($urandom_range(99) < 80)
                begin
                    node = NODE_W'($urandom_range(live - 1));
                end
                else
                begin
                    node = NODE_W'($urandom);
                end
                r = $urandom_range(99);
                if (r < 10)
                begin
                    weight = '0;
                end
                else if (r < 20)
                begin
                    weight = '1;
                end
                else if (r < 50)
                begin
                    weight = WEIGHT_W'($urandom_range(255));
                end
                else
                begin
                    weight = $urandom;
                end
                push_item(cmd, node, weight);
            end
        end
        steady = 1'b0;

        drain_results(SETTLE_CYCLES);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("[least_loaded_node_assigner_top] OK");
        end
        else
        begin
            $display("[least_loaded_node_assigner_top] ERROR");
        end
        $finish;
    end

endmodule
